/* hdl/ea2rm_pkg.sv */
// Package for the ZYX Euler angle to rotation matrix block.
// Holds payload structs, CORDIC constants and the arctangent table. No dependencies.
package ea2rm_pkg;

  localparam int AngleBits   = 16;
  localparam int CordicIters = 30;
  localparam int CordicFrac  = 30;
  localparam int CordicW     = 34;
  localparam logic signed [CordicW-1:0] CordicGainInv = 34'sd652032874;

  typedef struct packed {
    logic [15:0] yaw_angle;
    logic [15:0] pitch_angle;
    logic [15:0] roll_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] elem_r0c0;
    logic signed [15:0] elem_r0c1;
    logic signed [15:0] elem_r0c2;
    logic signed [15:0] elem_r1c0;
    logic signed [15:0] elem_r1c1;
    logic signed [15:0] elem_r1c2;
    logic signed [15:0] elem_r2c0;
    logic signed [15:0] elem_r2c1;
    logic signed [15:0] elem_r2c2;
  } out_item_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [CordicW-1:0] atan_turn(input logic [4:0] i);
    logic signed [CordicW-1:0] v;
    begin
      case (i)
        5'd0:  v = 34'sd536870912;
        5'd1:  v = 34'sd316933406;
        5'd2:  v = 34'sd167458907;
        5'd3:  v = 34'sd85004756;
        5'd4:  v = 34'sd42667331;
        5'd5:  v = 34'sd21354465;
        5'd6:  v = 34'sd10679838;
        5'd7:  v = 34'sd5340245;
        5'd8:  v = 34'sd2670163;
        5'd9:  v = 34'sd1335087;
        5'd10: v = 34'sd667544;
        5'd11: v = 34'sd333772;
        5'd12: v = 34'sd166886;
        5'd13: v = 34'sd83443;
        5'd14: v = 34'sd41722;
        5'd15: v = 34'sd20861;
        5'd16: v = 34'sd10430;
        5'd17: v = 34'sd5215;
        5'd18: v = 34'sd2608;
        5'd19: v = 34'sd1304;
        5'd20: v = 34'sd652;
        5'd21: v = 34'sd326;
        5'd22: v = 34'sd163;
        5'd23: v = 34'sd81;
        5'd24: v = 34'sd41;
        5'd25: v = 34'sd20;
        5'd26: v = 34'sd10;
        5'd27: v = 34'sd5;
        5'd28: v = 34'sd3;
        5'd29: v = 34'sd1;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

/* hdl/ea2rm_cordic_stage.sv */
// One CORDIC rotation-mode iteration, registered, for three angles in parallel lanes.
// Depends on ea2rm_pkg.
module ea2rm_cordic_stage #(
  parameter int Iter = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic vld_i,
  input  logic [2:0][ea2rm_pkg::CordicW-1:0] x_i,
  input  logic [2:0][ea2rm_pkg::CordicW-1:0] y_i,
  input  logic [2:0][ea2rm_pkg::CordicW-1:0] z_i,
  input  logic [2:0][1:0] q_i,
  output logic vld_o,
  output logic [2:0][ea2rm_pkg::CordicW-1:0] x_o,
  output logic [2:0][ea2rm_pkg::CordicW-1:0] y_o,
  output logic [2:0][ea2rm_pkg::CordicW-1:0] z_o,
  output logic [2:0][1:0] q_o
);
  localparam logic signed [ea2rm_pkg::CordicW-1:0] Atan = ea2rm_pkg::atan_turn(5'(Iter));

  logic vld_r;
  logic [2:0][ea2rm_pkg::CordicW-1:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic [2:0][1:0] q_r;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      logic signed [ea2rm_pkg::CordicW-1:0] xs, ys, zs, dx, dy;
      xs = x_i[l];
      ys = y_i[l];
      zs = z_i[l];
      dx = ys >>> Iter;
      dy = xs >>> Iter;
      if (!zs[ea2rm_pkg::CordicW-1]) begin
        x_nxt[l] = xs - dx;
        y_nxt[l] = ys + dy;
        z_nxt[l] = zs - Atan;
      end else begin
        x_nxt[l] = xs + dx;
        y_nxt[l] = ys - dy;
        z_nxt[l] = zs + Atan;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_i;
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    q_r <= q_i;
  end

  assign vld_o = vld_r;
  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;
  assign q_o = q_r;
endmodule

/* hdl/ea2rm_matrix.sv */
// Matrix build: three registered stages of rounded Q products, sums and saturation.
// Depends on ea2rm_pkg.
module ea2rm_matrix (
  input  logic clk,
  input  logic rst_n,
  input  logic vld_i,
  input  logic signed [15:0] cy_i, sy_i, cp_i, sp_i, cr_i, sr_i,
  output logic vld_o,
  output ea2rm_pkg::out_item_t res_o
);
  localparam int Fb = 14;

  function automatic logic signed [17:0] mulf(input logic signed [17:0] a,
                                             input logic signed [17:0] b);
    logic signed [35:0] p;
    begin
      p = a * b + 36'sd8192;
      return 18'(p >>> Fb);
    end
  endfunction

  function automatic logic signed [15:0] sat(input logic signed [18:0] v);
    begin
      if (v > 19'sd16384) return 16'sd16384;
      else if (v < -19'sd16384) return -16'sd16384;
      else return 16'(v);
    end
  endfunction

  // stage A: pair products
  logic va_r, vb_r, vc_r;
  logic signed [17:0] cpcy_r, cysp_r, crsy_x_r, crcy_r, sysr_r, cpsy_r, sysp_r, crsy_r;
  logic signed [17:0] cysr_r, cpsr_r, cpcr_r, sp_a_r, sr_a_r;
  // stage B: triple products
  logic signed [17:0] t01_r, t02_r, t11_r, t12_r;
  logic signed [17:0] b_cpcy_r, b_crsy_r, b_sysr_r, b_crcy_r, b_cysr_r;
  logic signed [17:0] b_cpsy_r, b_sp_r, b_cpsr_r, b_cpcr_r;
  ea2rm_pkg::out_item_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0; vb_r <= 1'b0; vc_r <= 1'b0;
    end else begin
      va_r <= vld_i; vb_r <= va_r; vc_r <= vb_r;
    end
    cpcy_r <= mulf(18'(cp_i), 18'(cy_i));
    cysp_r <= mulf(18'(cy_i), 18'(sp_i));
    crsy_x_r <= mulf(18'(cr_i), 18'(sy_i));
    crcy_r <= mulf(18'(cr_i), 18'(cy_i));
    sysr_r <= mulf(18'(sy_i), 18'(sr_i));
    cpsy_r <= mulf(18'(cp_i), 18'(sy_i));
    sysp_r <= mulf(18'(sy_i), 18'(sp_i));
    crsy_r <= mulf(18'(cr_i), 18'(sy_i));
    cysr_r <= mulf(18'(cy_i), 18'(sr_i));
    cpsr_r <= mulf(18'(cp_i), 18'(sr_i));
    cpcr_r <= mulf(18'(cp_i), 18'(cr_i));
    sp_a_r <= 18'(sp_i);
    sr_a_r <= 18'(sr_i);

    t01_r <= mulf(cysp_r, sr_a_r);
    t02_r <= mulf(crcy_r, sp_a_r);
    t11_r <= mulf(sysp_r, sr_a_r);
    t12_r <= mulf(crsy_x_r, sp_a_r);
    b_cpcy_r <= cpcy_r; b_crsy_r <= crsy_r; b_sysr_r <= sysr_r;
    b_crcy_r <= crcy_r; b_cysr_r <= cysr_r; b_cpsy_r <= cpsy_r;
    b_sp_r <= sp_a_r; b_cpsr_r <= cpsr_r; b_cpcr_r <= cpcr_r;

    res_r.elem_r0c0 <= sat(19'(b_cpcy_r));
    res_r.elem_r0c1 <= sat(19'(t01_r) - 19'(b_crsy_r));
    res_r.elem_r0c2 <= sat(19'(t02_r) + 19'(b_sysr_r));
    res_r.elem_r1c0 <= sat(19'(b_cpsy_r));
    res_r.elem_r1c1 <= sat(19'(t11_r) + 19'(b_crcy_r));
    res_r.elem_r1c2 <= sat(19'(t12_r) - 19'(b_cysr_r));
    res_r.elem_r2c0 <= sat(-19'(b_sp_r));
    res_r.elem_r2c1 <= sat(19'(b_cpsr_r));
    res_r.elem_r2c2 <= sat(19'(b_cpcr_r));
  end

  assign vld_o = vc_r;
  assign res_o = res_r;
endmodule

/* hdl/euler_angles_to_rotation_matrix_top.sv */
// Top level: ZYX Euler angles to rotation matrix, fully pipelined.
// Depends on ea2rm_pkg, ea2rm_cordic_stage, ea2rm_matrix.
//
//  channel | ports                       | handshake
//  --------+-----------------------------+-------------------------------
//  input   | in_item (yaw/pitch/roll)    | start high, busy low
//  result  | out_item (nine Q1.14 elems) | out_strobe, one cycle, no stall
//
// One transaction enters per cycle; busy is tied low since the result side
// cannot stall. The pipe runs angle prep, one CORDIC iteration per stage,
// rounding and quadrant map, then products, triple products and sums.
// Synchronous active-low reset clears only the valid bits along the pipe.
module euler_angles_to_rotation_matrix_top (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  ea2rm_pkg::in_item_t in_item,
  output logic out_strobe,
  output ea2rm_pkg::out_item_t out_item
);
  localparam int N = ea2rm_pkg::CordicIters;
  localparam int W = ea2rm_pkg::CordicW;

  logic accept;
  assign busy = 1'b0;
  assign accept = start && !busy;

  // angle prep: mask, scale to 32 bits per turn, split quadrant
  logic [2:0][15:0] ang;
  assign ang[0] = in_item.yaw_angle;
  assign ang[1] = in_item.pitch_angle;
  assign ang[2] = in_item.roll_angle;

  logic [N:0] vld;
  logic [N:0][2:0][W-1:0] xs, ys, zs;
  logic [N:0][2:0][1:0] qs;
  logic v0_r;
  logic [2:0][W-1:0] z0_r;
  logic [2:0][1:0] q0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else v0_r <= accept;
    for (int l = 0; l < 3; l++) begin
      logic [31:0] a32;
      a32 = 32'(ang[l][ea2rm_pkg::AngleBits-1:0]) << (32 - ea2rm_pkg::AngleBits);
      q0_r[l] <= a32[31:30];
      z0_r[l] <= W'({2'b00, a32[29:0]});
    end
  end

  assign vld[0] = v0_r;
  assign qs[0] = q0_r;
  assign zs[0] = z0_r;
  assign xs[0] = {3{ea2rm_pkg::CordicGainInv}};
  assign ys[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cordic
    ea2rm_cordic_stage #(.Iter(i)) u_stage (
      .clk(clk), .rst_n(rst_n),
      .vld_i(vld[i]), .x_i(xs[i]), .y_i(ys[i]), .z_i(zs[i]), .q_i(qs[i]),
      .vld_o(vld[i+1]), .x_o(xs[i+1]), .y_o(ys[i+1]), .z_o(zs[i+1]), .q_o(qs[i+1])
    );
  end

  // round to Q1.14, clamp, quadrant map
  function automatic logic signed [15:0] rnd(input logic signed [W-1:0] v);
    logic signed [W-1:0] t;
    begin
      t = (v + W'(32'sd32768)) >>> 16;
      if (t > W'(32'sd16384)) return 16'sd16384;
      else if (t < -W'(32'sd16384)) return -16'sd16384;
      else return 16'(t);
    end
  endfunction

  logic vsc_r;
  logic [2:0][15:0] c_r, s_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vsc_r <= 1'b0;
    else vsc_r <= vld[N];
    for (int l = 0; l < 3; l++) begin
      logic signed [15:0] c, s;
      c = rnd(xs[N][l]);
      s = rnd(ys[N][l]);
      case (qs[N][l])
        2'd0: begin c_r[l] <= c;  s_r[l] <= s;  end
        2'd1: begin c_r[l] <= -s; s_r[l] <= c;  end
        2'd2: begin c_r[l] <= -c; s_r[l] <= -s; end
        default: begin c_r[l] <= s; s_r[l] <= -c; end
      endcase
    end
  end

  ea2rm_matrix u_matrix (
    .clk(clk), .rst_n(rst_n), .vld_i(vsc_r),
    .cy_i(c_r[0]), .sy_i(s_r[0]), .cp_i(c_r[1]), .sp_i(s_r[1]),
    .cr_i(c_r[2]), .sr_i(s_r[2]),
    .vld_o(out_strobe), .res_o(out_item)
  );

  // element r2c0 is -sin(pitch), so it never exceeds one in magnitude
  a_r2c0_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.elem_r2c0 <= 16'sd16384 && out_item.elem_r2c0 >= -16'sd16384))
    else $error("r2c0 out of range");
  a_sc_follows: assert property (@(posedge clk) disable iff (!rst_n)
    vld[N] |=> vsc_r) else $error("sin/cos valid lost");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    vsc_r |-> ##3 out_strobe) else $error("matrix valid lost");
endmodule

/* bench/euler_angles_to_rotation_matrix_top_test.sv */
// Testbench for euler_angles_to_rotation_matrix_top: directed and random angle triples,
// each result checked against a bit-exact fixed-point CORDIC rotation matrix predictor.
// Depends on ea2rm_pkg and the RTL of euler_angles_to_rotation_matrix_top.
module euler_angles_to_rotation_matrix_top_test;

  localparam int FracBits = 14;
  localparam int Latency  = 35;

  // Expected matrices, oldest first; compares each output transaction.
  class matrix_scoreboard;
    ea2rm_pkg::out_item_t pending_mats[$];
    int        errors;

    // Floor division by 2^s, exact for negative values.
    function automatic longint floor_shift(longint v, int s);
      return v >>> s;
    endfunction

    function automatic longint clamp_one(longint v);
      longint one;
      one = longint'(1) << FracBits;
      if (v > one) return one;
      if (v < -one) return -one;
      return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
      return floor_shift(a * b + (longint'(1) << (FracBits - 1)), FracBits);
    endfunction

    // CORDIC in rotation mode on the in-quadrant remainder, then quadrant mapping.
    function automatic void trig(logic [15:0] ang, output longint co, output longint si);
      logic [31:0] a32;
      longint      x, y, z, dx, dy, c, s, atan_i;
      int          sh;
      a32 = {ang, 16'h0000};
      z   = longint'(a32[29:0]);
      x   = 652032874;
      y   = 0;
      for (int i = 0; i < 30; i++) begin
        dx     = floor_shift(y, i);
        dy     = floor_shift(x, i);
        atan_i = longint'(ea2rm_pkg::atan_turn(i[4:0]));
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_i;
        end else begin
          x += dx; y -= dy; z += atan_i;
        end
      end
      sh = 30 - FracBits;
      c  = clamp_one(floor_shift(x + (longint'(1) << (sh - 1)), sh));
      s  = clamp_one(floor_shift(y + (longint'(1) << (sh - 1)), sh));
      case (a32[31:30])
        2'd0: begin co = c;  si = s;  end
        2'd1: begin co = -s; si = c;  end
        2'd2: begin co = -c; si = -s; end
        default: begin co = s; si = -c; end
      endcase
    endfunction

    function automatic logic signed [15:0] sat16(longint v);
      longint t;
      t = clamp_one(v);
      return t[15:0];
    endfunction

    function void note_angles(ea2rm_pkg::in_item_t a);
      longint    cy, sy, cp, sp, cr, sr;
      ea2rm_pkg::out_item_t m;
      trig(a.yaw_angle, cy, sy);
      trig(a.pitch_angle, cp, sp);
      trig(a.roll_angle, cr, sr);
      m.elem_r0c0 = sat16(qmul(cp, cy));
      m.elem_r0c1 = sat16(qmul(qmul(cy, sp), sr) - qmul(cr, sy));
      m.elem_r0c2 = sat16(qmul(qmul(cr, cy), sp) + qmul(sy, sr));
      m.elem_r1c0 = sat16(qmul(cp, sy));
      m.elem_r1c1 = sat16(qmul(qmul(sy, sp), sr) + qmul(cr, cy));
      m.elem_r1c2 = sat16(qmul(qmul(cr, sy), sp) - qmul(cy, sr));
      m.elem_r2c0 = sat16(-sp);
      m.elem_r2c1 = sat16(qmul(cp, sr));
      m.elem_r2c2 = sat16(qmul(cp, cr));
      pending_mats.insert(pending_mats.size(), m);
    endfunction

    function void check_matrix(ea2rm_pkg::out_item_t got);
      ea2rm_pkg::out_item_t want;
      logic [15:0] w [9];
      logic [15:0] g [9];
      if (pending_mats.size() == 0) begin
        $display("%0t: unexpected matrix %h", $time, got);
        errors++;
        return;
      end
      want = pending_mats.pop_front();
      {w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8]} = want;
      {g[0], g[1], g[2], g[3], g[4], g[5], g[6], g[7], g[8]} = got;
      for (int k = 0; k < 9; k++)
        if (w[k] !== g[k]) begin
          $display("%0t: elem r%0dc%0d expected %0d actual %0d", $time, k / 3, k % 3,
                   $signed(w[k]), $signed(g[k]));
          errors++;
        end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  ea2rm_pkg::in_item_t  in_item;
  logic      out_strobe;
  ea2rm_pkg::out_item_t out_item;

  matrix_scoreboard sb;

  euler_angles_to_rotation_matrix_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_strobe(out_strobe), .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: far beyond ~1100 transactions with long gaps plus pipe latency.
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result monitor: results cannot be stalled, so sample every strobe.
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) sb.check_matrix(out_item);
  end

  // Mostly short idle gaps, now and then a long one, often none.
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) :
        ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Present one angle triple and hold it until the block takes the transaction.
  task automatic send_angles(logic [15:0] yaw, logic [15:0] pitch, logic [15:0] roll);
    ea2rm_pkg::in_item_t a;
    a.yaw_angle   = yaw;
    a.pitch_angle = pitch;
    a.roll_angle  = roll;
    start   <= 1'b1;
    in_item <= a;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_angles(a);
  endtask

  // Angles biased toward quadrant boundaries, where sign and saturation flip.
  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 3))
      0: return {2'($urandom_range(0, 3)), 14'h0000} + 16'($urandom_range(0, 4)) - 16'd2;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int wait_cnt;
    logic [15:0] edge_angs [8];
    sb      = new();
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero, quarter turns, extremes of each field.
    edge_angs = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                  16'hFFFF, 16'h0001, 16'h3FFF, 16'h2000};
    for (int k = 0; k < 8; k++) send_angles(edge_angs[k], 16'h0000, 16'h0000);
    for (int k = 0; k < 8; k++) send_angles(16'h0000, edge_angs[k], edge_angs[7 - k]);
    send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_angles(16'h5555, 16'hAAAA, 16'h5555);
    send_angles(16'hAAAA, 16'h5555, 16'hAAAA);
    send_angles(16'h4000, 16'h4000, 16'h4000);

    // Random transactions with random idle gaps.
    for (int n = 0; n < 1050; n++) begin
      idle_gap();
      send_angles(pick_angle(), pick_angle(), pick_angle());
    end
    start <= 1'b0;

    wait_cnt = 0;
    while (sb.pending_mats.size() != 0 && wait_cnt < 1000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (Latency + 5) @(posedge clk);
    if (sb.errors == 0 && sb.pending_mats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

/* filelist.f */
hdl/ea2rm_pkg.sv
hdl/ea2rm_cordic_stage.sv
hdl/ea2rm_matrix.sv
hdl/euler_angles_to_rotation_matrix_top.sv
bench/euler_angles_to_rotation_matrix_top_test.sv
